FILE: rtl/msk_pkg.sv
`timescale 1ns / 1ps

package msk_pkg;

	localparam int VAL_W     = 32;
	localparam int RANK_W    = 11;
	localparam int DEPTH_DEF = 1024;

	localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

	// controller -> datapath
	typedef struct packed {
		logic accept;      // item channel may transfer
		logic setup;       // compute run bounds for the pair at lo
		logic merge_step;  // move one element into the destination buffer
		logic pair_next;   // advance lo to the end of the finished pair
		logic pass_next;   // double run width, swap buffers
		logic result_load; // capture the result, clear the set
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_xfer;
		logic sort_more;
		logic pair_done;
		logic pass_done;
		logic out_free;
	} st_t;

endpackage

FILE: rtl/msk_ifs.sv
`timescale 1ns / 1ps

interface msk_item_if;
	logic                              valid;
	logic                              ready;
	logic signed [msk_pkg::VAL_W-1:0]  value;
	logic                              last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

interface msk_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [msk_pkg::VAL_W-1:0]  selected_value;
	logic                              rank_missing;
	logic                              overflow;

	modport source (output valid, selected_value, rank_missing, overflow, input ready);
	modport sink   (input valid, selected_value, rank_missing, overflow, output ready);
endinterface

interface msk_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [msk_pkg::RANK_W-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/msk_ram.sv
`timescale 1ns / 1ps

module msk_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [W-1:0]             rdata_a,
	output logic [W-1:0]             rdata_b
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/msk_ctrl.sv
`timescale 1ns / 1ps

module msk_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  msk_pkg::st_t   st,
	output msk_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_MERGE  = 3'd3;
	localparam logic [2:0] S_RANK   = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				cmd.accept = 1'b1;
				if (st.last_xfer) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = st.sort_more ? S_SETUP : S_RANK;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_MERGE;
			end
			S_MERGE: begin
				if (!st.pair_done) begin
					cmd.merge_step = 1'b1;
				end else if (!st.pass_done) begin
					cmd.pair_next = 1'b1;
					state_d       = S_SETUP;
				end else begin
					cmd.pass_next = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_RANK: begin
				// read of the ranked entry is in flight
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/msk_dp.sv
`timescale 1ns / 1ps

module msk_dp #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	msk_item_if.sink      item,
	msk_result_if.source  result,
	msk_cfg_if.sink       cfg,
	input  msk_pkg::cmd_t cmd,
	output msk_pkg::st_t  st
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = CW + 1;
	localparam int SW = CW + 2;
	localparam int VW = msk_pkg::VAL_W;
	localparam int RW = (msk_pkg::RANK_W > CW) ? msk_pkg::RANK_W : CW;

	logic [msk_pkg::RANK_W-1:0] rank_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [WW-1:0] width_q;
	logic [CW-1:0] lo_q, mid_q, hi_q;
	logic [CW-1:0] lptr_q, rptr_q, k_q;
	logic [CW-1:0] lptr_d, rptr_d;
	logic          cur_q;

	logic          out_valid_q;
	logic [VW-1:0] sel_q;
	logic          missing_q;
	logic          out_ovf_q;

	logic          load, room;
	logic [SW-1:0] sum_mid, sum_hi, n_ext;
	logic [CW-1:0] mid_c, hi_c;
	logic          l_ok, r_ok, take_l;
	logic [VW-1:0] m0_a, m0_b, m1_a, m1_b, rd_a, rd_b;
	logic [RW-1:0] rank_m1;
	logic          rank_ok;
	logic [AW-1:0] raddr_a, raddr_b, waddr0, waddr1;
	logic [VW-1:0] wdata0, merge_data;
	logic          we0, we1;

	assign item.ready = cmd.accept;
	assign cfg.ready  = 1'b1;
	assign load       = item.valid && item.ready;
	assign room       = count_q < CW'(DEPTH);

	// run bounds for the pair starting at lo, clipped to the set size
	assign n_ext   = SW'(count_q);
	assign sum_mid = SW'(lo_q) + SW'(width_q);
	assign sum_hi  = sum_mid + SW'(width_q);
	assign mid_c   = (sum_mid > n_ext) ? count_q : sum_mid[CW-1:0];
	assign hi_c    = (sum_hi > n_ext) ? count_q : sum_hi[CW-1:0];

	assign rd_a = cur_q ? m1_a : m0_a;
	assign rd_b = cur_q ? m1_b : m0_b;

	// ties go to the left run
	assign l_ok   = lptr_q < mid_q;
	assign r_ok   = rptr_q < hi_q;
	assign take_l = l_ok && (!r_ok || ($signed(rd_a) <= $signed(rd_b)));
	assign merge_data = take_l ? rd_a : rd_b;

	always_comb begin
		lptr_d = lptr_q;
		rptr_d = rptr_q;
		if (cmd.setup) begin
			lptr_d = lo_q;
			rptr_d = mid_c;
		end else if (cmd.merge_step) begin
			if (take_l) begin
				lptr_d = lptr_q + CW'(1);
			end else begin
				rptr_d = rptr_q + CW'(1);
			end
		end
	end

	assign rank_m1 = RW'(rank_q) - RW'(1);
	assign rank_ok = (rank_q != '0) && (RW'(rank_q) <= RW'(count_q));

	assign raddr_a = (cmd.setup || cmd.merge_step) ? lptr_d[AW-1:0] : rank_m1[AW-1:0];
	assign raddr_b = rptr_d[AW-1:0];

	assign we0    = (load && room) || (cmd.merge_step && cur_q);
	assign waddr0 = cmd.merge_step ? k_q[AW-1:0] : count_q[AW-1:0];
	assign wdata0 = cmd.merge_step ? merge_data : VW'(item.value);
	assign we1    = cmd.merge_step && !cur_q;
	assign waddr1 = k_q[AW-1:0];

	msk_ram #(.W(VW), .DEPTH(DEPTH)) u_ram0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr0),
		.wdata   (wdata0),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (m0_a),
		.rdata_b (m0_b)
	);

	msk_ram #(.W(VW), .DEPTH(DEPTH)) u_ram1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr1),
		.wdata   (merge_data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (m1_a),
		.rdata_b (m1_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= msk_pkg::RANK_RESET;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			width_q     <= WW'(1);
			lo_q        <= '0;
			cur_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				rank_q <= cfg.data;
			end
			if (load) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.pair_next) begin
				lo_q <= hi_q;
			end
			if (cmd.pass_next) begin
				width_q <= width_q << 1;
				lo_q    <= '0;
				cur_q   <= !cur_q;
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				ovf_q       <= 1'b0;
				width_q     <= WW'(1);
				lo_q        <= '0;
				cur_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lptr_q <= lptr_d;
		rptr_q <= rptr_d;
		if (cmd.setup) begin
			mid_q <= mid_c;
			hi_q  <= hi_c;
			k_q   <= lo_q;
		end else if (cmd.merge_step) begin
			k_q <= k_q + CW'(1);
		end
		if (cmd.result_load) begin
			sel_q     <= rank_ok ? rd_a : '0;
			missing_q <= !rank_ok;
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.selected_value = $signed(sel_q);
	assign result.rank_missing   = missing_q;
	assign result.overflow       = out_ovf_q;

	assign st.last_xfer = load && item.last;
	assign st.sort_more = WW'(count_q) > width_q;
	assign st.pair_done = !l_ok && !r_ok;
	assign st.pass_done = hi_q == count_q;
	assign st.out_free  = !out_valid_q || result.ready;

endmodule

FILE: rtl/merge_sort_kth_select_top.sv
`timescale 1ns / 1ps
// Sorts a set of signed 32-bit values and reports the one at a chosen rank.
// Values arrive one per transfer on the item channel, one per cycle, until a
// transfer with last set; that value belongs to the set. Up to DEPTH values
// are kept, further ones are dropped and flagged in overflow. The set is then
// sorted ascending by a bottom-up merge sort that ping-pongs between two
// DEPTH-entry RAMs, and one transfer on the result channel gives the value at
// the 1-based rank in rank_q (written on the cfg channel, reset 1).
// rank_missing is set, with a zero value, when the rank is 0 or exceeds the
// number of kept values. After loading, a set of n kept values takes
// ceil(log2 n) merge passes; each pass sets up and merges every pair of runs,
// the merge writing one element per cycle through a two-read-port RAM, and
// a rank lookup in the sorted buffer follows. The item channel stays closed
// from the last transfer until the result is captured in the output
// register; a held result does not block loading of the next set.

module merge_sort_kth_select_top #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	msk_item_if.sink      item,
	msk_result_if.source  result,
	msk_cfg_if.sink       cfg
);

	msk_pkg::cmd_t cmd;
	msk_pkg::st_t  st;

	// sequencing of load, merge passes and result
	msk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// buffers, pointers, comparator, counters and the output register
	msk_dp #(.DEPTH(DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st)
	);

endmodule

FILE: rtl/msk_chk.sv
`timescale 1ns / 1ps

module msk_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             item_last,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [msk_pkg::VAL_W-1:0] res_value,
	input logic                             res_missing
);

	// a held result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// closing transfer of a set shuts the item channel while sorting
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_last |=> !item_ready)
		else $error("item channel open after last transfer");

	// a new result is only produced while loading is closed
	a_res_after_sort: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(item_ready))
		else $error("result appeared during loading");

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_missing |-> res_value == '0)
		else $error("nonzero value with rank missing");

endmodule

bind merge_sort_kth_select_top msk_chk u_msk_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_last   (item.last),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_value   (result.selected_value),
	.res_missing (result.rank_missing)
);
